// File: design/wabs_pkg.sv
// Shared constants, types and helper functions for the window-average
// background subtraction core. No dependencies.
package wabs_pkg;

  // Geometry of the frame store and the history ring.
  localparam int MAX_WINDOW      = 8;
  localparam int MAX_FRAME_BYTES = 65536;
  localparam int PIX_W           = 8;
  localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);
  localparam int SLOT_W          = $clog2(MAX_WINDOW);
  localparam int K_W             = 4;
  localparam int CNT_W           = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W           = $clog2(MAX_WINDOW * 255 + 1);
  localparam int HIST_AW         = SLOT_W + IDX_W;
  localparam int THR_W           = 8;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = PIX_W + IDX_W;
  localparam int OUT_TDATA_W = PIX_W;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Result queue that decouples the pipeline from the output handshake.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

  // Reciprocal multiply for floor(sum / k): with m = ceil(2^(SUM_W+SLOT_W) / k)
  // the product shifted right by SUM_W+SLOT_W is exact for every sum.
  localparam int RECIP_SHIFT = SUM_W + SLOT_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((1 << RECIP_SHIFT));
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((1 << RECIP_SHIFT) + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((1 << RECIP_SHIFT) + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'(((1 << RECIP_SHIFT) + 6) / 7);
  localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'(((1 << RECIP_SHIFT) + 7) / 8);

  // Register reset values and the foreground marker.
  localparam logic [K_W-1:0]   WINDOW_RESET = K_W'(5);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(40);
  localparam logic [PIX_W-1:0] FG_ON        = PIX_W'(255);

  // Register map, indexed by word address.
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_THRESH = 1'b1
  } cfg_reg_t;

  // Request into the average and compare pipeline.
  typedef struct packed {
    logic              valid;
    logic              hist_ready;
    logic [PIX_W-1:0]  pix;
    logic [SUM_W-1:0]  sum;
  } wabs_cmp_req_t;

  // Finished result beat.
  typedef struct packed {
    logic              valid;
    logic              hist_ready;
    logic [PIX_W-1:0]  fg;
  } wabs_result_t;

  // Window length in force: zero acts as one, anything above the ring as the ring.
  function automatic logic [K_W-1:0] eff_window(input logic [K_W-1:0] wf);
    logic [K_W-1:0] k;
    if (wf == '0) begin
      k = K_W'(1);
    end else if (wf > K_W'(MAX_WINDOW)) begin
      k = K_W'(MAX_WINDOW);
    end else begin
      k = wf;
    end
    return k;
  endfunction

  // Rounded-up reciprocal for each legal window length.
  function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      K_W'(1):  m = RECIP_1;
      K_W'(2):  m = RECIP_2;
      K_W'(3):  m = RECIP_3;
      K_W'(4):  m = RECIP_4;
      K_W'(5):  m = RECIP_5;
      K_W'(6):  m = RECIP_6;
      K_W'(7):  m = RECIP_7;
      K_W'(8):  m = RECIP_8;
      default:  m = RECIP_1;
    endcase
    return m;
  endfunction

endpackage

// File: design/wabs_hist_store.sv
// Frame history ring: one byte per slot and position, one read and one write
// port, registered read data. Depends on wabs_pkg.
module wabs_hist_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [wabs_pkg::HIST_AW-1:0] rd_addr,
  output logic [wabs_pkg::PIX_W-1:0]   rd_data,
  input  logic                         wr_en,
  input  logic [wabs_pkg::HIST_AW-1:0] wr_addr,
  input  logic [wabs_pkg::PIX_W-1:0]   wr_data
);
  import wabs_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WINDOW * MAX_FRAME_BYTES];
  logic [PIX_W-1:0] rd_data_r;

  // Read returns the contents before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/wabs_sum_store.sv
// Per-position running sums with a clearing sweep after reset or restart.
// One read and one write port, registered read data. Depends on wabs_pkg.
module wabs_sum_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr_start,
  output logic                       busy,
  input  logic                       rd_en,
  input  logic [wabs_pkg::IDX_W-1:0] rd_addr,
  output logic [wabs_pkg::SUM_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [wabs_pkg::IDX_W-1:0] wr_addr,
  input  logic [wabs_pkg::SUM_W-1:0] wr_data
);
  import wabs_pkg::*;

  logic [SUM_W-1:0] mem [MAX_FRAME_BYTES];
  logic [SUM_W-1:0] rd_data_r;
  logic             clr_active_r;
  logic [IDX_W-1:0] clr_addr_r;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [SUM_W-1:0] wd;

  // Sweep control: one entry cleared per cycle, every entry once.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_start) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // The sweep owns the write port while it runs.
  always_comb begin
    if (clr_active_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

// File: design/wabs_fg_cmp.sv
// Two-stage average and threshold unit: reciprocal multiply for sum / k,
// then the absolute difference against the threshold. Depends on wabs_pkg.
module wabs_fg_cmp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wabs_pkg::K_W-1:0]   k,
  input  logic [wabs_pkg::THR_W-1:0] thr,
  input  wabs_pkg::wabs_cmp_req_t    req,
  output wabs_pkg::wabs_result_t     res
);
  import wabs_pkg::*;

  logic              a_valid_r;
  logic              a_rdy_r;
  logic [PIX_W-1:0]  a_pix_r;
  logic [PROD_W-1:0] a_prod_r;
  logic [PIX_W-1:0]  avg;
  logic [PIX_W-1:0]  diff;
  wabs_result_t      res_r;

  // Stage A: multiply the old sum by the reciprocal of k.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= req.valid;
    end
    a_rdy_r  <= req.hist_ready;
    a_pix_r  <= req.pix;
    a_prod_r <= PROD_W'(req.sum) * PROD_W'(recip(k));
  end

  // The average of stored bytes never exceeds a byte.
  assign avg  = a_prod_r[RECIP_SHIFT +: PIX_W];
  assign diff = (a_pix_r > avg) ? (a_pix_r - avg) : (avg - a_pix_r);

  // Stage B: compare and mark the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= a_valid_r;
    end
    res_r.hist_ready <= a_rdy_r;
    res_r.fg         <= (a_rdy_r && (diff > thr)) ? FG_ON : '0;
  end

  assign res = res_r;

endmodule

// File: design/wabs_out_fifo.sv
// Small result queue between the pipeline and the output handshake.
// Depends on wabs_pkg.
module wabs_out_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wabs_pkg::wabs_result_t   push,
  input  logic                     pop,
  output logic                     head_valid,
  output logic                     head_ready,
  output logic [wabs_pkg::PIX_W-1:0] head_fg
);
  import wabs_pkg::*;

  logic [PIX_W:0]  q_r [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_r;
  logic [OUT_AW-1:0] rd_ptr_r;
  logic [OCC_W-1:0]  count_r;
  logic              do_pop;

  assign do_pop = pop && (count_r != '0);

  // Pointers and fill count; the top level's credit keeps pushes from overflowing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + OUT_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_AW'(1);
      end
      count_r <= count_r + OCC_W'(push.valid) - OCC_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_r[wr_ptr_r] <= {push.hist_ready, push.fg};
    end
  end

  assign head_valid = (count_r != '0);
  assign head_ready = q_r[rd_ptr_r][PIX_W];
  assign head_fg    = q_r[rd_ptr_r][PIX_W-1:0];

endmodule

// File: design/window_average_background_subtract_core.sv
// Top level of the window-average background subtraction core: control,
// history ring pointers, read-modify-write of sums and history, result queue.
// Depends on wabs_pkg, wabs_hist_store, wabs_sum_store, wabs_fg_cmp, wabs_out_fifo.
//
//  Channel | Direction | Beat contents
//  --------+-----------+----------------------------------------------------
//  in_     | slave     | tdata: pixel_value, pixel_index; tlast: frame_end
//  out_    | master    | tdata: foreground; tuser: history_ready
//  cfg_    | APB       | 0x0 window_frames, 0x4 diff_threshold
//
// One pixel beat is accepted per clock while in_tready is high; its result
// goes through write-back, the compare stages and the result queue to out_.
// The sum and history memories are read in the accept cycle and written back
// the next cycle, with a one-entry forward for back-to-back hits.
// After reset, and after each write of window_frames, a clearing pass over
// every entry of the sum memory holds in_tready low.
// in_tready also drops when eight results are in flight or waiting at out_.
module window_average_background_subtract_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wabs_pkg::IN_TDATA_W-1:0]   in_tdata,   // pixel_value, pixel_index
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wabs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // foreground
  output logic                              out_tuser,  // history_ready
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wabs_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [wabs_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [wabs_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import wabs_pkg::*;

  // Configuration.
  logic [K_W-1:0]   wf_r;
  logic [THR_W-1:0] thr_r;
  logic             cfg_wr;
  cfg_reg_t         reg_sel;
  logic             restart;
  logic [K_W-1:0]   k;

  // Ring state.
  logic [CNT_W-1:0]  fs_r;
  logic [SLOT_W-1:0] oldest_r;
  logic              hist_rdy;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W:0]   oldest_inc;

  // Input beat.
  logic              in_acc;
  logic [PIX_W-1:0]  pix_in;
  logic [IDX_W-1:0]  pos_in;

  // Write-back stage.
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [IDX_W-1:0]  s1_pos_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_rdy_r;
  logic [SUM_W-1:0]  sum_rd;
  logic [PIX_W-1:0]  hist_rd;
  logic [SUM_W-1:0]  sum_old;
  logic [PIX_W-1:0]  hist_old;
  logic [SUM_W-1:0]  sum_new;

  // Forward of the previous cycle's write.
  logic                fw_valid_r;
  logic [IDX_W-1:0]    fw_pos_r;
  logic [HIST_AW-1:0]  fw_haddr_r;
  logic [SUM_W-1:0]    fw_sum_r;
  logic [PIX_W-1:0]    fw_hist_r;

  // Credit and queue.
  logic              clr_busy;
  logic [OCC_W-1:0]  occ_r;
  logic              out_acc;
  wabs_cmp_req_t     cmp_req;
  wabs_result_t      cmp_res;

  // APB decode; a write completes in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_reg_t'(cfg_paddr[2]);
  assign restart    = cfg_wr && (reg_sel == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wf_r  <= WINDOW_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WINDOW: wf_r  <= cfg_pwdata[K_W-1:0];
        REG_THRESH: thr_r <= cfg_pwdata[THR_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW: cfg_prdata = CFG_DW'(wf_r);
      REG_THRESH: cfg_prdata = CFG_DW'(thr_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign k = eff_window(wf_r);

  // Input handshake and beat fields.
  assign in_tready = !clr_busy && (occ_r < OCC_W'(OUT_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign pix_in    = in_tdata[PIX_W-1:0];
  assign pos_in    = in_tdata[PIX_W +: IDX_W];

  // Slot choice: the oldest frame once the window is full, else the next free one.
  assign hist_rdy = (K_W'(fs_r) >= k);
  assign slot_sum = (SLOT_W+1)'(oldest_r) + (hist_rdy ? '0 : (SLOT_W+1)'(fs_r));
  assign slot     = ((K_W'(slot_sum) >= k) ? SLOT_W'(K_W'(slot_sum) - k)
                                            : SLOT_W'(slot_sum));
  assign oldest_inc = (SLOT_W+1)'(oldest_r) + (SLOT_W+1)'(1);

  // Ring pointers advance on the last beat of a frame.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      fs_r     <= '0;
      oldest_r <= '0;
    end else if (in_acc && in_tlast) begin
      if (!hist_rdy) begin
        fs_r <= fs_r + CNT_W'(1);
      end else if (K_W'(oldest_inc) >= k) begin
        oldest_r <= '0;
      end else begin
        oldest_r <= SLOT_W'(oldest_inc);
      end
    end
  end

  // Memories: read in the accept cycle, write back in the next.
  wabs_sum_store u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (restart),
    .busy      (clr_busy),
    .rd_en     (in_acc),
    .rd_addr   (pos_in),
    .rd_data   (sum_rd),
    .wr_en     (s1_valid_r),
    .wr_addr   (s1_pos_r),
    .wr_data   (sum_new)
  );

  wabs_hist_store u_hist (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr ({slot, pos_in}),
    .rd_data (hist_rd),
    .wr_en   (s1_valid_r),
    .wr_addr ({s1_slot_r, s1_pos_r}),
    .wr_data (s1_pix_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fw_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      fw_valid_r <= s1_valid_r;
    end
    s1_pix_r   <= pix_in;
    s1_pos_r   <= pos_in;
    s1_slot_r  <= slot;
    s1_rdy_r   <= hist_rdy;
    fw_pos_r   <= s1_pos_r;
    fw_haddr_r <= {s1_slot_r, s1_pos_r};
    fw_sum_r   <= sum_new;
    fw_hist_r  <= s1_pix_r;
  end

  // A write committed while this beat's read was under way is taken from the forward.
  assign sum_old  = (fw_valid_r && (fw_pos_r == s1_pos_r)) ? fw_sum_r : sum_rd;
  assign hist_old = (fw_valid_r && (fw_haddr_r == {s1_slot_r, s1_pos_r})) ? fw_hist_r
                                                                          : hist_rd;
  assign sum_new  = sum_old - (s1_rdy_r ? SUM_W'(hist_old) : '0) + SUM_W'(s1_pix_r);

  // Average and compare on the sum as it stood before this beat.
  assign cmp_req.valid      = s1_valid_r;
  assign cmp_req.hist_ready = s1_rdy_r;
  assign cmp_req.pix        = s1_pix_r;
  assign cmp_req.sum        = sum_old;

  wabs_fg_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .k     (k),
    .thr   (thr_r),
    .req   (cmp_req),
    .res   (cmp_res)
  );

  wabs_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmp_res),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head_ready (out_tuser),
    .head_fg    (out_tdata)
  );

  // Beats accepted and not yet delivered; bounds the queue fill.
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  // Checks.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(OUT_DEPTH))
    else $error("in-flight count exceeds the result queue");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("input taken during the clearing pass");

  a_fs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    K_W'(fs_r) <= k)
    else $error("stored frame count exceeds the window");

  a_not_ready_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("foreground marked before the history is ready");

  a_credit_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=> (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("in-flight count missed an accepted beat");

endmodule
